FILE: rtl/core/fqrr_pkg.sv
package fqrr_pkg;

	// Fixed field widths of the channels
	localparam int unsigned NUM_LANES = 4;
	localparam int unsigned LANE_W    = 2;
	localparam int unsigned REQ_W     = 2;
	localparam int unsigned SEL_W     = 3;
	localparam int unsigned ID_W      = 16;
	localparam int unsigned STATUS_W  = 2;

	// Request codes
	localparam logic [REQ_W-1:0] REQ_SELECT = 2'd0;
	localparam logic [REQ_W-1:0] REQ_PUSH   = 2'd1;
	localparam logic [REQ_W-1:0] REQ_DRAIN  = 2'd2;

	// Result status codes
	localparam logic [STATUS_W-1:0] ST_ITEM  = 2'd0;
	localparam logic [STATUS_W-1:0] ST_DROP  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

	// Commands handed from the front to the back
	typedef enum logic [1:0] {
		CMD_PUSH,
		CMD_DROP,
		CMD_DRAIN,
		CMD_EMPTY
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t         kind;
		logic [LANE_W-1:0] lane;
		logic [ID_W-1:0]   id;
	} cmd_t;

endpackage

FILE: rtl/core/fqrr_in_if.sv
interface fqrr_in_if;
	logic                         valid;
	logic                         ready;
	logic [fqrr_pkg::REQ_W-1:0]   req_type;
	logic [fqrr_pkg::SEL_W-1:0]   lane_sel;
	logic [fqrr_pkg::ID_W-1:0]    item_id;

	modport source (output valid, req_type, lane_sel, item_id, input ready);
	modport sink   (input valid, req_type, lane_sel, item_id, output ready);
endinterface

FILE: rtl/core/fqrr_out_if.sv
interface fqrr_out_if;
	logic                            valid;
	logic                            ready;
	logic [fqrr_pkg::ID_W-1:0]       out_id;
	logic [fqrr_pkg::SEL_W-1:0]      out_lane;
	logic [fqrr_pkg::STATUS_W-1:0]   status;
	logic                            last;

	modport source (output valid, out_id, out_lane, status, last, input ready);
	modport sink   (input valid, out_id, out_lane, status, last, output ready);
endinterface

FILE: rtl/core/fqrr_ram.sv
module fqrr_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// One write port, one registered read port; read data holds without rd_en
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

FILE: rtl/core/fqrr_cmd_fifo.sv
module fqrr_cmd_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	output logic            push_ready,
	input  fqrr_pkg::cmd_t  push_data,
	output logic            pop_valid,
	input  logic            pop_ready,
	output fqrr_pkg::cmd_t  pop_data
);
	import fqrr_pkg::*;

	cmd_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;
	logic       do_push;
	logic       do_pop;

	assign push_ready = (fill_q != 2'd2);
	assign pop_valid  = (fill_q != 2'd0);
	assign pop_data   = slot_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + 2'd1;
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

	// Entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

FILE: rtl/core/fqrr_front.sv
module fqrr_front #(
	parameter int unsigned QUEUE_DEPTH = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	fqrr_in_if.sink         req,
	output logic            cmd_valid,
	input  logic            cmd_ready,
	output fqrr_pkg::cmd_t  cmd
);
	import fqrr_pkg::*;

	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [LANE_W-1:0] cur_lane_q;
	logic [CNT_W-1:0]  cnt_q [NUM_LANES];
	logic              accept;
	logic              lane_full;
	logic              all_empty;

	assign req.ready = cmd_ready;
	assign accept    = req.valid && req.ready;
	assign lane_full = (cnt_q[cur_lane_q] == CNT_W'(QUEUE_DEPTH));
	assign all_empty = (cnt_q[0] == '0) && (cnt_q[1] == '0) &&
		(cnt_q[2] == '0) && (cnt_q[3] == '0);

	// Classify the request into a command for the back end
	always_comb begin
		cmd_valid = 1'b0;
		cmd.kind  = CMD_PUSH;
		cmd.lane  = cur_lane_q;
		cmd.id    = req.item_id;
		if (req.valid) begin
			if (req.req_type == REQ_PUSH) begin
				cmd_valid = 1'b1;
				cmd.kind  = lane_full ? CMD_DROP : CMD_PUSH;
			end else if (req.req_type == REQ_DRAIN) begin
				cmd_valid = 1'b1;
				cmd.kind  = all_empty ? CMD_EMPTY : CMD_DRAIN;
			end
		end
	end

	// Current lane and shadow occupancy for full / empty decisions
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_lane_q <= '0;
			for (int i = 0; i < NUM_LANES; i++) begin
				cnt_q[i] <= '0;
			end
		end else if (accept) begin
			if (req.req_type == REQ_SELECT) begin
				if (req.lane_sel >= SEL_W'(1) && req.lane_sel <= SEL_W'(NUM_LANES)) begin
					cur_lane_q <= LANE_W'(req.lane_sel - SEL_W'(1));
				end
			end else if (req.req_type == REQ_PUSH) begin
				if (!lane_full) begin
					cnt_q[cur_lane_q] <= cnt_q[cur_lane_q] + CNT_W'(1);
				end
			end else if (req.req_type == REQ_DRAIN) begin
				for (int i = 0; i < NUM_LANES; i++) begin
					cnt_q[i] <= '0;
				end
			end
		end
	end

endmodule

FILE: rtl/core/fqrr_back.sv
module fqrr_back #(
	parameter int unsigned QUEUE_DEPTH = 16,
	parameter int unsigned ID_BITS     = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cmd_valid,
	output logic            cmd_ready,
	input  fqrr_pkg::cmd_t  cmd,
	fqrr_out_if.source      rsp
);
	import fqrr_pkg::*;

	localparam int unsigned STORE_W = (ID_BITS < ID_W) ? ID_BITS : ID_W;
	localparam int unsigned SLOT_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned CNT_W   = $clog2(QUEUE_DEPTH + 1);
	localparam int unsigned TOT_W   = $clog2(NUM_LANES * QUEUE_DEPTH + 1);
	localparam int unsigned ADDR_W  = LANE_W + SLOT_W;
	localparam int unsigned SUM_W   = CNT_W + 1;

	// Lanes 1, 3, 2, 4 as zero-based indices
	localparam logic [LANE_W-1:0] VISIT [NUM_LANES] = '{2'd0, 2'd2, 2'd1, 2'd3};

	logic [SLOT_W-1:0] head_q [NUM_LANES];
	logic [CNT_W-1:0]  cnt_q  [NUM_LANES];
	logic [TOT_W-1:0]  total_q;
	logic [LANE_W-1:0] vpos_q;

	logic                out_valid_q;
	logic                out_ram_q;
	logic [ID_W-1:0]     out_id_q;
	logic [SEL_W-1:0]    out_lane_q;
	logic [STATUS_W-1:0] out_status_q;
	logic                out_last_q;

	logic                advance;
	logic                load_out;
	logic [LANE_W-1:0]   pick_lane;
	logic [LANE_W-1:0]   pick_pos;
	logic [SUM_W-1:0]    tail_sum;
	logic [SLOT_W-1:0]   tail_slot;
	logic                ram_wr;
	logic                ram_rd;
	logic [STORE_W-1:0]  ram_rd_data;
	logic                drain_last;

	assign advance = !out_valid_q || rsp.ready;

	// First non-empty lane in visiting order, starting where the round left off
	always_comb begin
		logic             found;
		logic [LANE_W-1:0] pos;
		found     = 1'b0;
		pick_pos  = vpos_q;
		pick_lane = VISIT[vpos_q];
		for (int i = 0; i < NUM_LANES; i++) begin
			pos = vpos_q + LANE_W'(i);
			if (!found && cnt_q[VISIT[pos]] != '0) begin
				found     = 1'b1;
				pick_pos  = pos;
				pick_lane = VISIT[pos];
			end
		end
	end

	// Write slot of a push: (head + count) mod depth
	assign tail_sum  = SUM_W'(head_q[cmd.lane]) + SUM_W'(cnt_q[cmd.lane]);
	assign tail_slot = (tail_sum >= SUM_W'(QUEUE_DEPTH)) ?
		SLOT_W'(tail_sum - SUM_W'(QUEUE_DEPTH)) : SLOT_W'(tail_sum);

	assign drain_last = (total_q == TOT_W'(1));

	// Command execution
	always_comb begin
		cmd_ready = 1'b0;
		ram_wr    = 1'b0;
		ram_rd    = 1'b0;
		load_out  = 1'b0;
		if (cmd_valid) begin
			unique case (cmd.kind)
				CMD_PUSH: begin
					ram_wr    = 1'b1;
					cmd_ready = 1'b1;
				end
				CMD_DROP, CMD_EMPTY: begin
					load_out  = advance;
					cmd_ready = advance;
				end
				CMD_DRAIN: begin
					ram_rd    = advance;
					load_out  = advance;
					cmd_ready = advance && drain_last;
				end
				default: begin
					cmd_ready = 1'b1;
				end
			endcase
		end
	end

	fqrr_ram #(
		.WIDTH (STORE_W),
		.DEPTH (2 ** ADDR_W)
	) u_store (
		.clk     (clk),
		.wr_en   (ram_wr),
		.wr_addr ({cmd.lane, tail_slot}),
		.wr_data (cmd.id[STORE_W-1:0]),
		.rd_en   (ram_rd),
		.rd_addr ({pick_lane, head_q[pick_lane]}),
		.rd_data (ram_rd_data)
	);

	// Lane pointers, round position and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_LANES; i++) begin
				head_q[i] <= '0;
				cnt_q[i]  <= '0;
			end
			total_q     <= '0;
			vpos_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			if (ram_wr) begin
				cnt_q[cmd.lane] <= cnt_q[cmd.lane] + CNT_W'(1);
				total_q         <= total_q + TOT_W'(1);
			end
			if (ram_rd) begin
				cnt_q[pick_lane]  <= cnt_q[pick_lane] - CNT_W'(1);
				head_q[pick_lane] <= (head_q[pick_lane] == SLOT_W'(QUEUE_DEPTH - 1)) ?
					'0 : head_q[pick_lane] + SLOT_W'(1);
				total_q <= total_q - TOT_W'(1);
				vpos_q  <= drain_last ? '0 : pick_pos + LANE_W'(1);
			end
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (load_out) begin
			out_ram_q <= (cmd.kind == CMD_DRAIN);
			unique case (cmd.kind)
				CMD_DROP: begin
					out_id_q     <= ID_W'(cmd.id[STORE_W-1:0]);
					out_lane_q   <= SEL_W'(cmd.lane) + SEL_W'(1);
					out_status_q <= ST_DROP;
					out_last_q   <= 1'b1;
				end
				CMD_DRAIN: begin
					out_id_q     <= '0;
					out_lane_q   <= SEL_W'(pick_lane) + SEL_W'(1);
					out_status_q <= ST_ITEM;
					out_last_q   <= drain_last;
				end
				default: begin
					out_id_q     <= '0;
					out_lane_q   <= '0;
					out_status_q <= ST_EMPTY;
					out_last_q   <= 1'b1;
				end
			endcase
		end
	end

	assign rsp.valid    = out_valid_q;
	assign rsp.out_id   = out_ram_q ? ID_W'(ram_rd_data) : out_id_q;
	assign rsp.out_lane = out_lane_q;
	assign rsp.status   = out_status_q;
	assign rsp.last     = out_last_q;

	// Running total tracks the lane counts
	a_total_matches: assert property (@(posedge clk) disable iff (!arst_n)
		total_q == TOT_W'(cnt_q[0]) + TOT_W'(cnt_q[1]) + TOT_W'(cnt_q[2]) + TOT_W'(cnt_q[3]))
		else $error("total out of step with lane counts");

	// Pushes wait while a drain reads
	a_no_wr_during_rd: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_wr && ram_rd))
		else $error("store written and read in the same cycle");

	// Final drain read leaves every lane empty and restarts the round
	a_last_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_rd && drain_last) |=> (total_q == '0 && vpos_q == '0))
		else $error("drain ended with lanes still occupied");

	// No lane over capacity
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q[0] <= CNT_W'(QUEUE_DEPTH) && cnt_q[1] <= CNT_W'(QUEUE_DEPTH) &&
		cnt_q[2] <= CNT_W'(QUEUE_DEPTH) && cnt_q[3] <= CNT_W'(QUEUE_DEPTH))
		else $error("lane count above queue depth");

endmodule

FILE: rtl/core/four_queue_round_robin_drain_core.sv
// Four FIFO lanes (1 to 4) of QUEUE_DEPTH identifiers each, kept to ID_BITS bits.
// (16 at most). A select transaction sets the current lane, a push appends to it
// (a push to a full lane returns one status-1 result), and a drain empties all
// lanes in rounds visiting lanes 1, 3, 2, 4, one result per stored identifier with
// last on the final one, or a single status-2 result when every lane is empty. The
// front end takes one request per cycle while the queue has room and hands commands
// through a two-entry queue to the back end; selects stay in the front end, pushes
// go straight into the store, and a drain holds the back end until its last
// identifier is read, one store read each, while the front keeps accepting until
// the queue fills. Results leave through one output register; while a result waits
// to be taken, the back end holds any command that produces a result (pushes still
// go through) and the front keeps accepting until the queue fills.
module four_queue_round_robin_drain_core #(
	parameter int unsigned QUEUE_DEPTH = 16,
	parameter int unsigned ID_BITS     = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	fqrr_in_if.sink     req,
	fqrr_out_if.source  rsp
);
	import fqrr_pkg::*;

	logic cmd_in_valid;
	logic cmd_in_ready;
	cmd_t cmd_in;
	logic cmd_out_valid;
	logic cmd_out_ready;
	cmd_t cmd_out;

	fqrr_front #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd_valid (cmd_in_valid),
		.cmd_ready (cmd_in_ready),
		.cmd       (cmd_in)
	);

	fqrr_cmd_fifo u_cmd_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (cmd_in_valid),
		.push_ready (cmd_in_ready),
		.push_data  (cmd_in),
		.pop_valid  (cmd_out_valid),
		.pop_ready  (cmd_out_ready),
		.pop_data   (cmd_out)
	);

	fqrr_back #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.ID_BITS     (ID_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_out_valid),
		.cmd_ready (cmd_out_ready),
		.cmd       (cmd_out),
		.rsp       (rsp)
	);

endmodule
